/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, inactive while reset is held.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/dsched_pkg.sv */
`default_nettype none
package dsched_pkg;

    localparam int MAX_REQUESTS = 1024;
    localparam int TRACK_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int ARR_W        = 32;
    localparam int CLK_W        = 48;
    localparam int SVC_W        = 16;
    localparam int ENTRY_W      = ARR_W + TRACK_BITS;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CLK_W-1:0] CLK_MAX = {CLK_W{1'b1}};

    // Policy codes.
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_LOOK = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE = 1'b1;

    // One candidate found by the scan.
    typedef struct packed {
        logic                  found;
        logic [ADDR_W-1:0]     idx;
        logic [TRACK_BITS-1:0] trk;
        logic [TRACK_BITS-1:0] gap;
    } t_cand;

    // All candidates gathered by one scan of the pending set.
    typedef struct packed {
        t_cand first;
        t_cand near;
        t_cand same;
        t_cand up;
        t_cand down;
    } t_scan;

endpackage
`default_nettype wire

/* rtl/dsched_if.sv */
`default_nettype none
interface dsched_req_if;
    import dsched_pkg::*;
    logic             valid;
    logic             ready;
    logic [31:0]      arrival_time;
    logic [15:0]      track_number;
    logic             last_request;
    modport source (output valid, arrival_time, track_number, last_request, input ready);
    modport sink   (input valid, arrival_time, track_number, last_request, output ready);
endinterface

interface dsched_res_if;
    import dsched_pkg::*;
    logic             valid;
    logic             ready;
    logic [47:0]      finish_time;
    logic [15:0]      final_track;
    modport source (output valid, finish_time, final_track, input ready);
    modport sink   (input valid, finish_time, final_track, output ready);
endinterface
`default_nettype wire

/* rtl/dsched_ram.sv */
`default_nettype none
module dsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/dsched_scan.sv */
`default_nettype none
module dsched_scan (
    input  wire logic                             i_clk,
    input  wire logic                             i_clr,
    input  wire logic                             i_en,
    input  wire logic [dsched_pkg::ADDR_W-1:0]    i_idx,
    input  wire logic [dsched_pkg::TRACK_BITS-1:0] i_trk,
    input  wire logic                             i_served,
    input  wire logic [dsched_pkg::TRACK_BITS-1:0] i_head,
    output dsched_pkg::t_scan                     o_res
);
    import dsched_pkg::*;

    t_scan                 r_res;
    t_scan                 n_res;
    t_cand                 cur;
    logic [TRACK_BITS-1:0] gap;

    // Distance of the entry under the scan and its candidate record.
    always_comb begin
        gap       = (i_trk >= i_head) ? i_trk - i_head : i_head - i_trk;
        cur.found = 1'b1;
        cur.idx   = i_idx;
        cur.trk   = i_trk;
        cur.gap   = gap;
    end

    // Keep the earliest entry on ties: only a strictly better one replaces.
    always_comb begin
        n_res = r_res;
        if (i_clr) begin
            n_res = '0;
        end else if (i_en && !i_served) begin
            if (!r_res.first.found) begin
                n_res.first = cur;
            end
            if (!r_res.near.found || gap < r_res.near.gap) begin
                n_res.near = cur;
            end
            if (i_trk == i_head && !r_res.same.found) begin
                n_res.same = cur;
            end
            if (i_trk > i_head && (!r_res.up.found || gap < r_res.up.gap)) begin
                n_res.up = cur;
            end
            if (i_trk < i_head && (!r_res.down.found || gap < r_res.down.gap)) begin
                n_res.down = cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

/* rtl/disk_request_scheduler.sv */
// Loading: one request per cycle, ready stays high until the last request.
// Scheduling: each decision admits the entries that have arrived, clears the
// scan, walks the admitted entries one per cycle through the request memory
// read port and then picks the next request by the policy.
// The result waits in an output register; no request is taken until it is
// transferred. Reset is synchronous, active low.
`default_nettype none
module disk_request_scheduler (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dsched_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dsched_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dsched_req_if.sink                             i_req,
    dsched_res_if.source                           o_res
);
    import dsched_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_ADM_RD, S_ADM_CHK, S_SCAN_ST, S_SCAN, S_DECIDE, S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_policy;
    logic [SVC_W-1:0]      r_svc;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_seq;
    logic [CNT_W-1:0]      r_idx;
    logic [CLK_W-1:0]      r_clock;
    logic [TRACK_BITS-1:0] r_head;
    logic                  r_down;
    logic [ARR_W-1:0]      r_next_arr;
    logic                  r_out_vld;
    logic [CLK_W-1:0]      r_finish;
    logic [TRACK_BITS-1:0] r_ftrack;

    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  ram_we;
    logic                  srv_we;
    logic [ADDR_W-1:0]     srv_waddr;
    logic                  srv_wdata;
    logic                  srv_rdata;
    logic                  scan_clr;
    logic                  scan_en;
    t_scan                 scan;
    t_cand                 pick;
    logic                  flip;
    logic [ARR_W-1:0]      rd_arr;
    logic [TRACK_BITS-1:0] rd_trk;
    logic [CLK_W:0]        sum;
    logic                  load_xfer;

    assign rd_arr    = ram_rdata[ENTRY_W-1:TRACK_BITS];
    assign rd_trk    = ram_rdata[TRACK_BITS-1:0];
    assign load_xfer = i_req.valid && i_req.ready;

    // Read address for the next cycle's memory data.
    always_comb begin
        unique case (r_state)
            S_ADM_RD:  ram_raddr = r_seq[ADDR_W-1:0];
            S_ADM_CHK: ram_raddr = ADDR_W'(r_seq + CNT_W'(1));
            S_SCAN:    ram_raddr = ADDR_W'(r_idx + CNT_W'(1));
            default:   ram_raddr = '0;
        endcase
    end

    // Policy choice from the gathered candidates.
    always_comb begin
        flip = 1'b0;
        unique case (r_policy)
            POL_SSTF: pick = scan.near;
            POL_LOOK: begin
                if (scan.same.found) begin
                    pick = scan.same;
                end else if (!r_down) begin
                    pick = scan.up.found ? scan.up : scan.down;
                    flip = !scan.up.found && scan.down.found;
                end else begin
                    pick = scan.down.found ? scan.down : scan.up;
                    flip = !scan.down.found && scan.up.found;
                end
            end
            default:  pick = scan.first;
        endcase
    end

    assign sum = {1'b0, r_clock} + (CLK_W+1)'(pick.gap) + (CLK_W+1)'(r_svc);

    // Memory and scan unit control.
    assign ram_we    = (r_state == S_LOAD) && load_xfer && (r_count < CNT_W'(MAX_REQUESTS));
    assign srv_we    = ram_we || ((r_state == S_DECIDE) && pick.found);
    assign srv_waddr = ram_we ? r_count[ADDR_W-1:0] : pick.idx;
    assign srv_wdata = !ram_we;
    assign scan_clr  = (r_state == S_SCAN_ST);
    assign scan_en   = (r_state == S_SCAN);

    dsched_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REQUESTS)) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_req.arrival_time, i_req.track_number[TRACK_BITS-1:0]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dsched_ram #(.WIDTH(1), .DEPTH(MAX_REQUESTS)) u_srv_ram (
        .i_clk   (i_clk),
        .i_we    (srv_we),
        .i_waddr (srv_waddr),
        .i_wdata (srv_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (srv_rdata)
    );

    dsched_scan u_scan (
        .i_clk    (i_clk),
        .i_clr    (scan_clr),
        .i_en     (scan_en),
        .i_idx    (r_idx[ADDR_W-1:0]),
        .i_trk    (rd_trk),
        .i_served (srv_rdata),
        .i_head   (r_head),
        .o_res    (scan)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FCFS;
            r_svc    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POLICY:  r_policy <= i_cfg_data[1:0];
                REG_SERVICE: r_svc    <= i_cfg_data[SVC_W-1:0];
                default:     r_policy <= r_policy;
            endcase
        end
    end

    // Sequencer: load, admit, scan, decide, hand out the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_seq     <= '0;
            r_idx     <= '0;
            r_clock   <= '0;
            r_head    <= '0;
            r_down    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (load_xfer) begin
                        if (ram_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_req.last_request) begin
                            r_state <= S_ADM_RD;
                        end
                    end
                end
                S_ADM_RD: begin
                    r_state <= (r_seq < r_count) ? S_ADM_CHK : S_SCAN_ST;
                end
                S_ADM_CHK: begin
                    if (CLK_W'(rd_arr) <= r_clock) begin
                        r_seq <= r_seq + CNT_W'(1);
                        if (r_seq + CNT_W'(1) >= r_count) begin
                            r_state <= S_SCAN_ST;
                        end
                    end else begin
                        r_next_arr <= rd_arr;
                        r_state    <= S_SCAN_ST;
                    end
                end
                S_SCAN_ST: begin
                    r_idx   <= '0;
                    r_state <= (r_seq == '0) ? S_DECIDE : S_SCAN;
                end
                S_SCAN: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (r_idx + CNT_W'(1) >= r_seq) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (pick.found) begin
                        r_clock <= (sum >= (CLK_W+1)'(CLK_MAX)) ? CLK_MAX : sum[CLK_W-1:0];
                        r_head  <= pick.trk;
                        r_down  <= r_down ^ flip;
                        r_state <= S_ADM_RD;
                    end else if (r_seq < r_count) begin
                        r_clock <= CLK_W'(r_next_arr);
                        r_state <= S_ADM_RD;
                    end else begin
                        r_finish  <= r_clock;
                        r_ftrack  <= r_head;
                        r_out_vld <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (o_res.ready) begin
                        r_out_vld <= 1'b0;
                        r_count   <= '0;
                        r_seq     <= '0;
                        r_clock   <= '0;
                        r_head    <= '0;
                        r_down    <= 1'b0;
                        r_state   <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_LOAD);
    assign o_res.valid       = r_out_vld;
    assign o_res.finish_time = r_finish;
    assign o_res.final_track = 16'(r_ftrack);
endmodule
`default_nettype wire

/* rtl/dsched_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module dsched_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    // A waiting result holds until its transfer.
    `AST_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // No request is taken while a result is shown.
    `AST_SAME(a_no_overlap, i_out_valid, !i_in_ready)
    // The last request closes the input side after its transfer.
    `AST_NEXT(a_last_stops, i_in_valid && i_in_ready && i_in_last, !i_in_ready)
    // After a result transfer the block loads again.
    `AST_NEXT(a_reopen, i_out_valid && i_out_ready, i_in_ready && !i_out_valid)
endmodule

bind disk_request_scheduler dsched_checker u_dsched_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_last   (i_req.last_request),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dsched_pkg::*;

    typedef struct {
        bit [31:0] arrival;
        bit [15:0] track;
        bit        last;
    } disk_req_t;

    typedef struct {
        bit [47:0] finish_time;
        bit [15:0] final_track;
    } sched_outcome_t;

    localparam longint CLOCK_CEIL = 64'h0000_FFFF_FFFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dsched_req_if req_ch ();
    dsched_res_if res_ch ();

    disk_request_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #2 i_clk = ~i_clk;

    // Queues between stimulus, driver and checker.
    disk_req_t      pending_reqs[$];
    sched_outcome_t expected_outcomes[$];
    int             error_count = 0;

    // Shadow copies of the registers and of the scheduler state.
    logic [1:0]  policy_sh = POL_FCFS;
    bit   [15:0] service_sh = '0;
    bit   [31:0] arr_mem[MAX_REQUESTS];
    bit   [15:0] trk_mem[MAX_REQUESTS];
    bit          served[MAX_REQUESTS];
    int          stored_count = 0;
    longint      sched_clock = 0;
    bit   [15:0] head_pos = '0;
    bit          heading_down = 1'b0;

    // Idle control: burst mode turns all gaps off for a while.
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;

    function automatic longint seek_len(bit [15:0] a, bit [15:0] b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // Nearest unserved entry strictly above or below the head; lim if none.
    function automatic int nearest_toward(int lim, bit go_up);
        int     best;
        longint bd;
        longint d;
        best = lim;
        bd = 0;
        for (int i = 0; i < lim; i++) begin
            if (served[i]) continue;
            if (go_up ? (trk_mem[i] <= head_pos) : (trk_mem[i] >= head_pos)) continue;
            d = seek_len(trk_mem[i], head_pos);
            if (best == lim || d < bd) begin
                best = i;
                bd = d;
            end
        end
        return best;
    endfunction

    function automatic int choose_next(int lim);
        int     best;
        longint bd;
        longint d;
        best = lim;
        bd = 0;
        case (policy_sh)
            POL_SSTF: begin
                for (int i = 0; i < lim; i++) begin
                    if (served[i]) continue;
                    d = seek_len(trk_mem[i], head_pos);
                    if (best == lim || d < bd) begin
                        best = i;
                        bd = d;
                    end
                end
            end
            POL_LOOK: begin
                // A request on the current track wins outright.
                for (int i = 0; i < lim; i++)
                    if (!served[i] && trk_mem[i] == head_pos) return i;
                best = nearest_toward(lim, !heading_down);
                if (best == lim) begin
                    best = nearest_toward(lim, heading_down);
                    if (best != lim) heading_down = !heading_down;
                end
            end
            default: begin
                for (int i = 0; i < lim; i++)
                    if (!served[i]) return i;
            end
        endcase
        return best;
    endfunction

    // Run the whole schedule over the stored list and queue its outcome.
    function automatic void run_schedule_model();
        int             seq;
        int             k;
        longint         stepv;
        sched_outcome_t o;
        seq = 0;
        forever begin
            while (seq < stored_count && longint'(arr_mem[seq]) <= sched_clock) seq++;
            k = choose_next(seq);
            if (k < seq) begin
                stepv = seek_len(trk_mem[k], head_pos) + longint'(service_sh);
                sched_clock = (stepv >= CLOCK_CEIL - sched_clock) ? CLOCK_CEIL
                                                                  : sched_clock + stepv;
                head_pos = trk_mem[k];
                served[k] = 1'b1;
            end else if (seq < stored_count) begin
                sched_clock = longint'(arr_mem[seq]);
            end else begin
                break;
            end
        end
        o.finish_time = sched_clock[47:0];
        o.final_track = head_pos;
        expected_outcomes.push_back(o);
        for (int i = 0; i < MAX_REQUESTS; i++) served[i] = 1'b0;
        stored_count = 0;
        sched_clock = 0;
        head_pos = '0;
        heading_down = 1'b0;
    endfunction

    function automatic void take_request(disk_req_t r);
        if (stored_count < MAX_REQUESTS) begin
            arr_mem[stored_count] = r.arrival;
            trk_mem[stored_count] = r.track;
            served[stored_count] = 1'b0;
            stored_count++;
        end
        if (r.last) run_schedule_model();
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // Request driver: one item per transfer, random gaps between items.
    always @(posedge i_clk) begin
        disk_req_t r;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.arrival_time <= '0;
            req_ch.track_number <= '0;
            req_ch.last_request <= 1'b0;
            send_gap <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
            if (send_gap > 0) begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.arrival_time <= r.arrival;
                req_ch.track_number <= r.track;
                req_ch.last_request <= r.last;
                send_gap <= draw_wait(send_burst);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Request monitor: every accepted request goes to the predictor.
    always @(posedge i_clk) begin
        disk_req_t r;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r.arrival = req_ch.arrival_time;
            r.track = req_ch.track_number;
            r.last = req_ch.last_request;
            take_request(r);
        end
    end

    // Result sink: random stalls on ready, with occasional stall-free bursts.
    always @(posedge i_clk) begin
        int nxt;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) recv_burst <= !recv_burst;
            if (res_ch.valid && res_ch.ready) begin
                nxt = draw_wait(recv_burst);
                recv_stall <= nxt;
                res_ch.ready <= (nxt == 0);
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                res_ch.ready <= (recv_stall == 1);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        sched_outcome_t e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: time=%0d track=%0d",
                             res_ch.finish_time, res_ch.final_track);
            end else begin
                e = expected_outcomes.pop_front();
                if (res_ch.finish_time !== e.finish_time ||
                    res_ch.final_track !== e.final_track) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: time exp %0d got %0d, track exp %0d got %0d",
                                 e.finish_time, res_ch.finish_time,
                                 e.final_track, res_ch.final_track);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_POLICY) policy_sh = data[1:0];
        else service_sh = data;
    endtask

    task automatic set_mode(logic [1:0] pol, logic [15:0] svc);
        wait_idle();
        write_reg(REG_POLICY, {14'd0, pol});
        write_reg(REG_SERVICE, svc);
    endtask

    function automatic void push_req(bit [31:0] a, bit [15:0] t, bit l);
        disk_req_t r;
        r.arrival = a;
        r.track = t;
        r.last = l;
        pending_reqs.push_back(r);
    endfunction

    // One random list; mostly well-formed ascending arrivals.
    function automatic int push_random_list();
        int     len;
        longint arr;
        bit     narrow;
        bit     shuffled;
        len = $urandom_range(1, 12);
        narrow = ($urandom_range(0, 2) == 0);
        shuffled = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: arr = 0;
            1: arr = $urandom_range(0, 200);
            2: arr = longint'($urandom()) - 1000;
            default: arr = 64'hFFFF_FFFF - $urandom_range(0, 5000);
        endcase
        if (arr < 0) arr = 0;
        for (int i = 0; i < len; i++) begin
            if (shuffled) arr = longint'($urandom());
            else if ($urandom_range(0, 1)) arr = arr + $urandom_range(0, 300);
            if (arr > 64'hFFFF_FFFF) arr = 64'hFFFF_FFFF;
            push_req(arr[31:0],
                     narrow ? 16'($urandom_range(0, 15)) : 16'($urandom()),
                     i == len - 1);
        end
        return len;
    endfunction

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, out-of-order arrivals, every policy.
        set_mode(POL_FCFS, 16'd0);
        push_req(32'd0, 16'd0, 1'b1);
        push_req(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        push_req(32'd100, 16'd5, 1'b0);
        push_req(32'd10, 16'd7, 1'b0);
        push_req(32'd200, 16'hFFFF, 1'b1);

        set_mode(POL_SSTF, 16'hFFFF);
        push_req(32'd0, 16'd10, 1'b0);
        push_req(32'd0, 16'd30, 1'b0);
        push_req(32'd0, 16'd50, 1'b0);
        push_req(32'd0, 16'd0, 1'b1);

        set_mode(POL_LOOK, 16'd3);
        push_req(32'd0, 16'd0, 1'b0);
        push_req(32'd0, 16'd40, 1'b0);
        push_req(32'd0, 16'd20, 1'b0);
        push_req(32'd30, 16'd20, 1'b0);
        push_req(32'd60, 16'd5, 1'b0);
        push_req(32'd60, 16'd45, 1'b1);

        // The unused policy code behaves as first-come first-served.
        set_mode(2'd3, 16'd1);
        push_req(32'd0, 16'd900, 1'b0);
        push_req(32'd0, 16'd1, 1'b0);
        push_req(32'hFFFF_FFFF, 16'h8000, 1'b1);

        // Store full: the extra requests are dropped, the last one still starts it.
        set_mode(POL_FCFS, 16'd2);
        for (int i = 0; i < MAX_REQUESTS + 6; i++)
            push_req(32'd0, 16'($urandom()), i == MAX_REQUESTS + 5);

        // Random lists under a changing set of registers.
        sent = 0;
        while (sent < 600) begin
            case ($urandom_range(0, 3))
                0: set_mode(2'($urandom_range(0, 3)), 16'd0);
                1: set_mode(2'($urandom_range(0, 3)), 16'hFFFF);
                2: set_mode(2'($urandom_range(0, 3)), 16'($urandom_range(0, 20)));
                default: set_mode(2'($urandom_range(0, 3)), 16'($urandom()));
            endcase
            for (int n = 0; n < 100 && sent < 600; n += 0)
                n += push_random_list();
            sent += 100;
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
